// ===== rtl/tse_pkg.sv =====
`timescale 1ns / 1ps

package tse_pkg;

  // Fixed field widths of the item and result ports.
  localparam int unsigned VID_W = 4;  // vertex id on src/dst/vertex
  localparam int unsigned CFG_W = 5;  // vertex_count register
  localparam int unsigned CNT_W = 8;  // in-count / ready-stack link store

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
  localparam logic [CNT_W-1:0] CNT_FULL  = 8'hFF;

  // Controller -> datapath commands.
  typedef struct packed {
    logic add_rd;    // latch edge, read count of dst and list head of src
    logic add_wr;    // commit or drop the latched edge
    logic scan_init; // start of sort: rewind scan and stack
    logic scan_step; // one step of the zero in-count scan
    logic pop_rd;    // read link and list head of the stack top
    logic pop_emit;  // emit popped vertex, unlink it, fetch first edge
    logic err_emit;  // emit the cycle-found result
    logic edge_cnt;  // latch edge word, read count of its target
    logic edge_upd;  // decrement target count, push when it hits zero
    logic clear;     // drop the whole graph
  } tse_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic scan_done;
    logic top_empty;
    logic is_last;
    logic head_has_edge;
    logic nxt_has_edge;
  } tse_sts_t;

endpackage

// ===== rtl/tse_ctrl.sv =====
`timescale 1ns / 1ps

module tse_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              mode_i,
  input  tse_pkg::tse_sts_t sts_i,
  output tse_pkg::tse_cmd_t cmd_o,
  output logic              busy_o
);
  import tse_pkg::*;

  typedef enum logic [2:0] {
    IDLE, ADD, SCAN, POP, POP_RES, EDGE_CNT, EDGE_UPD, CLEAR
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      IDLE: begin
        if (start_i && !busy_q) begin
          if (mode_i) begin
            cmd_o.scan_init = 1'b1;
            state_d         = SCAN;
          end else begin
            cmd_o.add_rd = 1'b1;
            state_d      = ADD;
          end
        end
      end
      ADD: begin
        cmd_o.add_wr = 1'b1;
        state_d      = IDLE;
      end
      SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = POP;
        end
      end
      POP: begin
        if (sts_i.top_empty) begin
          cmd_o.err_emit = 1'b1;
          state_d        = CLEAR;
        end else begin
          cmd_o.pop_rd = 1'b1;
          state_d      = POP_RES;
        end
      end
      POP_RES: begin
        cmd_o.pop_emit = 1'b1;
        if (sts_i.is_last) begin
          state_d = CLEAR;
        end else if (sts_i.head_has_edge) begin
          state_d = EDGE_CNT;
        end else begin
          state_d = POP;
        end
      end
      EDGE_CNT: begin
        cmd_o.edge_cnt = 1'b1;
        state_d        = EDGE_UPD;
      end
      EDGE_UPD: begin
        cmd_o.edge_upd = 1'b1;
        state_d        = sts_i.nxt_has_edge ? EDGE_CNT : POP;
      end
      CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = IDLE;
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

// ===== rtl/tse_datapath.sv =====
`timescale 1ns / 1ps

module tse_datapath #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned MAX_EDGES    = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tse_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic [tse_pkg::VID_W-1:0]   src_i,
  input  logic [tse_pkg::VID_W-1:0]   dst_i,
  input  tse_pkg::tse_cmd_t           cmd_i,
  output tse_pkg::tse_sts_t           sts_o,
  output logic                        out_valid_o,
  output logic [tse_pkg::VID_W-1:0]   vertex_o,
  output logic                        last_o,
  output logic                        cycle_found_o,
  output logic                        edges_dropped_o
);
  import tse_pkg::*;

  localparam int unsigned VW  = $clog2(MAX_VERTICES);     // vertex index
  localparam int unsigned NW  = $clog2(MAX_VERTICES + 1); // vertex count / stack top
  localparam int unsigned EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EW  = $clog2(MAX_EDGES + 1);    // edge pointer incl. end mark
  localparam int unsigned EDW = VID_W + EW;               // edge word: {target, next}

  localparam logic [NW-1:0] NO_VERTEX = NW'(MAX_VERTICES);
  localparam logic [EW-1:0] NO_EDGE   = EW'(MAX_EDGES);

  // configuration
  logic [CFG_W-1:0] cfg_q;
  logic [NW-1:0]    n_eff;

  // vertex stores with per-entry valid bits
  logic [CNT_W-1:0] cnt_mem  [MAX_VERTICES];
  logic [EW-1:0]    head_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] cnt_vld_q, head_vld_q;
  logic [CNT_W-1:0] cnt_rdata_q;
  logic [EW-1:0]    head_rdata_q;
  logic             cnt_rvld_q, head_rvld_q;
  logic [CNT_W-1:0] cnt_rd;
  logic [EW-1:0]    head_rd;

  // edge pool
  logic [EDW-1:0]   edge_mem [MAX_EDGES];
  logic [EDW-1:0]   edge_rd_q;
  logic [VID_W-1:0] edge_tgt;
  logic [EW-1:0]    edge_nxt;

  // port controls
  logic [VW-1:0]    cnt_raddr, cnt_waddr, head_raddr, head_waddr;
  logic             cnt_we, head_we, edge_we;
  logic [CNT_W-1:0] cnt_wdata;
  logic [EW-1:0]    head_wdata;
  logic [EDW-1:0]   edge_wdata;
  logic [EIW-1:0]   edge_raddr;

  // control registers
  logic [EW-1:0] used_q, used_d;
  logic          drop_q, drop_d;
  logic [NW-1:0] top_q, top_d;
  logic [NW-1:0] emit_q, emit_d;
  logic [NW-1:0] scan_q, scan_d;
  logic          pend_q, pend_d;
  logic          out_vld_q, out_vld_d;

  // payload registers
  logic [VW-1:0]    pend_idx_q, pend_idx_d;
  logic [VW-1:0]    pop_idx_q, pop_idx_d;
  logic [VID_W-1:0] src_q, src_d, dst_q, dst_d, t_q, t_d;
  logic [EW-1:0]    nxt_q, nxt_d;
  logic [VID_W-1:0] out_vertex_q, out_vertex_d;
  logic             out_last_q, out_last_d, out_cyc_q, out_cyc_d, out_drop_q, out_drop_d;

  logic edge_ok;

  // vertex_count clamped into 1..MAX_VERTICES
  always_comb begin
    if (cfg_q == '0) begin
      n_eff = NW'(1);
    end else if (int'(cfg_q) > int'(MAX_VERTICES)) begin
      n_eff = NO_VERTEX;
    end else begin
      n_eff = NW'(cfg_q);
    end
  end

  // an entry never written since the last clear reads as its reset value
  assign cnt_rd   = cnt_rvld_q  ? cnt_rdata_q  : '0;
  assign head_rd  = head_rvld_q ? head_rdata_q : NO_EDGE;
  assign edge_tgt = edge_rd_q[EW +: VID_W];
  assign edge_nxt = edge_rd_q[EW-1:0];

  assign edge_ok = (int'(src_q) < int'(n_eff)) && (int'(dst_q) < int'(n_eff)) &&
                   (used_q < NO_EDGE) && (cnt_rd != CNT_FULL);

  assign sts_o.scan_done     = !pend_q && (scan_q == n_eff);
  assign sts_o.top_empty     = (top_q >= NO_VERTEX);
  assign sts_o.is_last       = ((emit_q + NW'(1)) == n_eff);
  assign sts_o.head_has_edge = (head_rd < NO_EDGE);
  assign sts_o.nxt_has_edge  = (nxt_q < NO_EDGE);

  always_comb begin
    // default read addresses serve an edge load issued at accept
    cnt_raddr  = VW'(dst_i);
    head_raddr = VW'(src_i);
    edge_raddr = EIW'(nxt_q);
    cnt_we     = 1'b0;
    cnt_waddr  = VW'(dst_q);
    cnt_wdata  = cnt_rd + 1'b1;
    head_we    = 1'b0;
    head_waddr = VW'(src_q);
    head_wdata = used_q;
    edge_we    = 1'b0;
    edge_wdata = {dst_q, head_rd};

    used_d       = used_q;
    drop_d       = drop_q;
    top_d        = top_q;
    emit_d       = emit_q;
    scan_d       = scan_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    pop_idx_d    = pop_idx_q;
    src_d        = src_q;
    dst_d        = dst_q;
    t_d          = t_q;
    nxt_d        = nxt_q;
    out_vld_d    = 1'b0;
    out_vertex_d = out_vertex_q;
    out_last_d   = out_last_q;
    out_cyc_d    = out_cyc_q;
    out_drop_d   = out_drop_q;

    if (cmd_i.add_rd) begin
      src_d = src_i;
      dst_d = dst_i;
    end

    if (cmd_i.add_wr) begin
      if (edge_ok) begin
        cnt_we  = 1'b1;
        head_we = 1'b1;
        edge_we = 1'b1;
        used_d  = used_q + 1'b1;
      end else begin
        drop_d = 1'b1;
      end
    end

    if (cmd_i.scan_init) begin
      top_d  = NO_VERTEX;
      scan_d = '0;
      pend_d = 1'b0;
      emit_d = '0;
    end

    if (cmd_i.scan_step) begin
      // push the vertex read last cycle if its count is zero
      if (pend_q && (cnt_rd == '0)) begin
        cnt_we    = 1'b1;
        cnt_waddr = pend_idx_q;
        cnt_wdata = CNT_W'(top_q);
        top_d     = NW'(pend_idx_q);
      end
      if (scan_q < n_eff) begin
        cnt_raddr  = scan_q[VW-1:0];
        pend_d     = 1'b1;
        pend_idx_d = scan_q[VW-1:0];
        scan_d     = scan_q + 1'b1;
      end else begin
        pend_d = 1'b0;
      end
    end

    if (cmd_i.pop_rd) begin
      cnt_raddr  = top_q[VW-1:0];
      head_raddr = top_q[VW-1:0];
      pop_idx_d  = top_q[VW-1:0];
    end

    if (cmd_i.pop_emit) begin
      top_d        = NW'(cnt_rd);
      emit_d       = emit_q + 1'b1;
      edge_raddr   = EIW'(head_rd);
      nxt_d        = head_rd;
      out_vld_d    = 1'b1;
      out_vertex_d = VID_W'(pop_idx_q);
      out_last_d   = sts_o.is_last;
      out_cyc_d    = 1'b0;
      out_drop_d   = drop_q;
    end

    if (cmd_i.edge_cnt) begin
      t_d       = edge_tgt;
      nxt_d     = edge_nxt;
      cnt_raddr = VW'(edge_tgt);
    end

    if (cmd_i.edge_upd) begin
      // targets beyond n are skipped; a zero entry is left alone
      if ((int'(t_q) < int'(n_eff)) && (cnt_rd != '0)) begin
        cnt_we    = 1'b1;
        cnt_waddr = VW'(t_q);
        if (cnt_rd == CNT_W'(1)) begin
          cnt_wdata = CNT_W'(top_q);
          top_d     = NW'(t_q);
        end else begin
          cnt_wdata = cnt_rd - 1'b1;
        end
      end
    end

    if (cmd_i.err_emit) begin
      out_vld_d    = 1'b1;
      out_vertex_d = '0;
      out_last_d   = 1'b1;
      out_cyc_d    = 1'b1;
      out_drop_d   = drop_q;
    end

    if (cmd_i.clear) begin
      used_d = '0;
      drop_d = 1'b0;
      top_d  = NO_VERTEX;
      emit_d = '0;
    end
  end

  // memories: one write and one registered read per store each cycle
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (edge_we) begin
      edge_mem[EIW'(used_q)] <= edge_wdata;
    end
    cnt_rdata_q  <= cnt_mem[cnt_raddr];
    cnt_rvld_q   <= cnt_vld_q[cnt_raddr];
    head_rdata_q <= head_mem[head_raddr];
    head_rvld_q  <= head_vld_q[head_raddr];
    edge_rd_q    <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q  <= '0;
      head_vld_q <= '0;
    end else if (cmd_i.clear) begin
      cnt_vld_q  <= '0;
      head_vld_q <= '0;
    end else begin
      if (cnt_we) begin
        cnt_vld_q[cnt_waddr] <= 1'b1;
      end
      if (head_we) begin
        head_vld_q[head_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= CFG_RESET;
      used_q    <= '0;
      drop_q    <= 1'b0;
      top_q     <= NO_VERTEX;
      emit_q    <= '0;
      scan_q    <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      used_q    <= used_d;
      drop_q    <= drop_d;
      top_q     <= top_d;
      emit_q    <= emit_d;
      scan_q    <= scan_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q   <= pend_idx_d;
    pop_idx_q    <= pop_idx_d;
    src_q        <= src_d;
    dst_q        <= dst_d;
    t_q          <= t_d;
    nxt_q        <= nxt_d;
    out_vertex_q <= out_vertex_d;
    out_last_q   <= out_last_d;
    out_cyc_q    <= out_cyc_d;
    out_drop_q   <= out_drop_d;
  end

  assign out_valid_o     = out_vld_q;
  assign vertex_o        = out_vertex_q;
  assign last_o          = out_last_q;
  assign cycle_found_o   = out_cyc_q;
  assign edges_dropped_o = out_drop_q;

endmodule

// ===== rtl/topological_sort_engine.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// ------------------------------------------------------------------------------
// command   in         start_i & !busy_o             mode_i, src_i, dst_i
// result    out        out_valid_o (one-cycle pulse) vertex_o, last_o,
//                                                    cycle_found_o, edges_dropped_o
// config    in         cfg_we_i                      cfg_data_i (vertex_count)
//
// An edge load reads the count and list head, then commits.
// A sort scans zero in-counts, pops ready vertices, walks edges, gives any cycle
// result, then clears; one registered read per store per cycle sets its pace.
// Results leave on out_valid_o and cannot be held off; busy_o stays high
// until the last result of a sort has gone out.
// rst_ni clears control state and the per-vertex valid bits; no clearing pass.

module topological_sort_engine #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned MAX_EDGES    = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command transfer
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      mode_i,
  input  logic [tse_pkg::VID_W-1:0] src_i,
  input  logic [tse_pkg::VID_W-1:0] dst_i,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [tse_pkg::CFG_W-1:0] cfg_data_i,
  // result transfer
  output logic                      out_valid_o,
  output logic [tse_pkg::VID_W-1:0] vertex_o,
  output logic                      last_o,
  output logic                      cycle_found_o,
  output logic                      edges_dropped_o
);
  import tse_pkg::*;

  tse_cmd_t cmd;
  tse_sts_t sts;

  // Sequencer: edge load, zero-count scan, pop, successor walk, clear.
  tse_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .mode_i  (mode_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Graph stores (in-count doubles as ready-stack link), edge pool, results.
  tse_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .src_i           (src_i),
    .dst_i           (dst_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .vertex_o        (vertex_o),
    .last_o          (last_o),
    .cycle_found_o   (cycle_found_o),
    .edges_dropped_o (edges_dropped_o)
  );

`ifndef SYNTHESIS
  // results only come out during a sort
  a_result_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_o)
    else $error("result outside of a sort");

  // the cycle result always ends the sort
  a_cycle_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cycle_found_o) |-> last_o)
    else $error("cycle result not marked last");

  // an edge load transfer passes through ADD back to idle and gives no result
  a_edge_load_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !mode_i) |=> (busy_o && !out_valid_o) ##1 !busy_o)
    else $error("edge load length wrong");

  // the block is free again right after the final result
  a_idle_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |=> (!busy_o && !out_valid_o))
    else $error("not idle after final result");
`endif

endmodule

// ===== tb/sv/tse_tb_pkg.sv =====
`timescale 1ns / 1ps

package tse_tb_pkg;

  // Meaning of mode_i on a command transfer.
  typedef enum logic {
    MODE_EDGE = 1'b0,
    MODE_SORT = 1'b1
  } mode_e;

endpackage

// ===== tb/sv/tse_order_checker.sv =====
`timescale 1ns / 1ps

module tse_order_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic                      mode_i,
  input  logic [tse_pkg::VID_W-1:0] src_i,
  input  logic [tse_pkg::VID_W-1:0] dst_i,
  input  logic                      cfg_we_i,
  input  logic [tse_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      out_valid_i,
  input  logic [tse_pkg::VID_W-1:0] vertex_i,
  input  logic                      last_i,
  input  logic                      cycle_found_i,
  input  logic                      edges_dropped_i,
  output int                        fail_count_o,
  output int                        pending_o
);
  import tse_pkg::*;
  import tse_tb_pkg::*;

  localparam int unsigned NUM_V = 16;
  localparam int unsigned NUM_E = 64;
  localparam logic [6:0]  NO_EDGE = 7'd64;

  typedef struct {
    logic [VID_W-1:0] vertex;
    logic             last;
    logic             cycle_found;
    logic             edges_dropped;
  } order_t;

  // Mirror of the graph held by the block.
  logic [CFG_W-1:0] vcount;
  logic [CNT_W-1:0] in_cnt [NUM_V];
  logic [6:0]       head   [NUM_V];
  logic [VID_W-1:0] e_tgt  [NUM_E];
  logic [6:0]       e_nxt  [NUM_E];
  int unsigned      used;
  logic             dropped;

  order_t order_q[$];
  int     fails;
  int     pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic int unsigned eff_n(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > NUM_V) return NUM_V;
    return v;
  endfunction

  function void clear_graph();
    for (int i = 0; i < NUM_V; i++) begin
      in_cnt[i] = '0;
      head[i]   = NO_EDGE;
    end
    for (int i = 0; i < NUM_E; i++) begin
      e_tgt[i] = '0;
      e_nxt[i] = '0;
    end
    used    = 0;
    dropped = 1'b0;
  endfunction

  function void load_edge(input logic [VID_W-1:0] u, input logic [VID_W-1:0] v);
    int unsigned n;
    n = eff_n(vcount);
    if (u >= n || v >= n || used >= NUM_E || in_cnt[v] == CNT_FULL) begin
      dropped = 1'b1;
    end else begin
      e_tgt[used] = v;
      e_nxt[used] = head[u];
      head[u]     = used[6:0];
      used        = used + 1;
      in_cnt[v]   = in_cnt[v] + 1'b1;
    end
  endfunction

  // Kahn's order with the ready LIFO threaded through the count store.
  function void kahn_order();
    int unsigned n, top, j, t, p;
    logic        drop;
    order_t      r;
    n    = eff_n(vcount);
    drop = dropped;
    top  = NUM_V;
    for (int i = 0; i < n; i++) begin
      if (in_cnt[i] == 0) begin
        in_cnt[i] = top[CNT_W-1:0];
        top       = i;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (top >= NUM_V) begin
        r = '{vertex: '0, last: 1'b1, cycle_found: 1'b1, edges_dropped: drop};
        order_q.push_back(r);
        break;
      end
      j   = top;
      top = in_cnt[j];
      r = '{vertex: j[VID_W-1:0], last: (i + 1 == n), cycle_found: 1'b0,
            edges_dropped: drop};
      order_q.push_back(r);
      p = head[j];
      while (p < NUM_E) begin
        t = e_tgt[p];
        if (t < n && in_cnt[t] != 0) begin
          in_cnt[t] = in_cnt[t] - 1'b1;
          if (in_cnt[t] == 0) begin
            in_cnt[t] = top[CNT_W-1:0];
            top       = t;
          end
        end
        p = e_nxt[p];
      end
    end
    clear_graph();
  endfunction

  task check_field(input string name, input logic [3:0] exp, input logic [3:0] act);
    if (act !== exp) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    order_t exp;
    if (!rst_ni) begin
      vcount = CFG_RESET;
      clear_graph();
      order_q.delete();
      fails = 0;
    end else begin
      if (out_valid_i) begin
        if (order_q.size() == 0) begin
          $error("unexpected result: vertex %0d", vertex_i);
          fails++;
        end else begin
          exp = order_q.pop_front();
          check_field("vertex", exp.vertex, vertex_i);
          check_field("last", exp.last, last_i);
          check_field("cycle_found", exp.cycle_found, cycle_found_i);
          check_field("edges_dropped", exp.edges_dropped, edges_dropped_i);
        end
      end
      if (cfg_we_i) vcount = cfg_data_i;
      if (start_i && !busy_i) begin
        if (mode_i == MODE_SORT) kahn_order();
        else load_edge(src_i, dst_i);
      end
    end
    pending = order_q.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tse_pkg::*;
  import tse_tb_pkg::*;

  localparam int unsigned LIMIT     = 500000; // cycle cap, far above a clean run
  localparam int unsigned SETTLE    = 8;      // quiet cycles after the last result
  localparam int unsigned RAND_ITEMS = 170;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             start_i    = 1'b0;
  logic             busy_o;
  logic             mode_i     = MODE_EDGE;
  logic [VID_W-1:0] src_i      = '0;
  logic [VID_W-1:0] dst_i      = '0;
  logic             cfg_we_i   = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic             out_valid_o;
  logic [VID_W-1:0] vertex_o;
  logic             last_o;
  logic             cycle_found_o;
  logic             edges_dropped_o;

  int               fails;
  int               pending;
  int unsigned      cycles = 0;
  int unsigned      items  = 0;
  int unsigned      n_eff  = 16;  // effective vertex count, stimulus side only
  bit               burst  = 1'b0; // back-to-back transfers, no idle gaps

  topological_sort_engine i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .src_i          (src_i),
    .dst_i          (dst_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .vertex_o       (vertex_o),
    .last_o         (last_o),
    .cycle_found_o  (cycle_found_o),
    .edges_dropped_o(edges_dropped_o)
  );

  // Checker sees the same pins as the block, predicts every result and
  // counts mismatches; the top only drives and judges.
  tse_order_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .mode_i         (mode_i),
    .src_i          (src_i),
    .dst_i          (dst_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_i    (out_valid_o),
    .vertex_i       (vertex_o),
    .last_i         (last_o),
    .cycle_found_i  (cycle_found_o),
    .edges_dropped_i(edges_dropped_o),
    .fail_count_o   (fails),
    .pending_o      (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung sort or a lost result ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Idle length before a transfer: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // One command transfer. start_i stays high across back-to-back transfers;
  // it is only lowered when a gap follows.
  task automatic send(input mode_e m, input logic [VID_W-1:0] s,
                      input logic [VID_W-1:0] d);
    int unsigned g;
    g = burst ? 0 : pick_gap();
    if (g != 0) begin
      start_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    start_i <= 1'b1;
    mode_i  <= m;
    src_i   <= s;
    dst_i   <= d;
    do @(posedge clk_i); while (busy_o);
    items++;
  endtask

  // Wait until every predicted result is out and the block has gone quiet.
  // Sampled on the falling edge so the checker's update at the rising edge
  // is already visible.
  task automatic settle();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy_o);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_W-1:0] v);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    n_eff = (v == 0) ? 1 : (v > 16) ? 16 : v;
  endtask

  // Register values, extremes weighted up: 0 and 31 exercise the clamp.
  function automatic logic [CFG_W-1:0] pick_cfg();
    case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd31;
      3: return 5'd16;
      4: return 5'd17;
      5: return 5'd2;
      default: return CFG_W'($urandom_range(0, 31));
    endcase
  endfunction

  initial begin
    logic [VID_W-1:0] perm [16];
    logic [VID_W-1:0] tmp;
    int unsigned      graph, n_edges, a, b, k, r;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---------------- directed ----------------
    // Reset width: all 16 vertices, a small DAG touching vertices 0 and 15.
    send(MODE_EDGE, 4'd0, 4'd15);
    send(MODE_EDGE, 4'd0, 4'd1);
    send(MODE_EDGE, 4'd1, 4'd15);
    send(MODE_EDGE, 4'd3, 4'd2);
    send(MODE_SORT, 4'd15, 4'd15);
    // Two-vertex cycle: the free vertices drain, then the error result.
    send(MODE_EDGE, 4'd2, 4'd3);
    send(MODE_EDGE, 4'd3, 4'd2);
    send(MODE_SORT, 4'd0, 4'd0);
    // Single vertex with a self loop, plus an out-of-range edge that is dropped.
    write_cfg(5'd1);
    send(MODE_EDGE, 4'd0, 4'd0);
    send(MODE_EDGE, 4'd5, 4'd9);
    send(MODE_SORT, 4'd0, 4'd0);
    // Register 0 behaves as one vertex: empty graph sorts to vertex 0 alone.
    write_cfg(5'd0);
    send(MODE_SORT, 4'd9, 4'd6);
    // Register above the maximum clamps to 16.
    write_cfg(5'd31);
    send(MODE_EDGE, 4'd15, 4'd14);
    send(MODE_EDGE, 4'd14, 4'd0);
    send(MODE_SORT, 4'd0, 4'd0);
    // Width lowered after loading: vertex 3 keeps an in-edge from 12 and
    // never becomes ready, so the sort ends in a cycle.
    write_cfg(5'd16);
    send(MODE_EDGE, 4'd12, 4'd3);
    send(MODE_EDGE, 4'd2, 4'd5);
    write_cfg(5'd8);
    send(MODE_SORT, 4'd0, 4'd0);
    write_cfg(5'd17);
    send(MODE_SORT, 4'd0, 4'd0);

    // ---------------- random graphs ----------------
    graph = 0;
    while (items < RAND_ITEMS) begin
      // Graph 3 fills the edge pool past its capacity at full width.
      if (graph == 3) write_cfg(5'd16);
      else if ($urandom_range(0, 2) == 0) write_cfg(pick_cfg());
      burst = ($urandom_range(0, 3) == 0);

      // Random vertex order; edges from lower to higher position form a DAG.
      for (int i = 0; i < 16; i++) perm[i] = VID_W'(i);
      for (int i = n_eff - 1; i > 0; i--) begin
        k = $urandom_range(0, i);
        tmp = perm[i];
        perm[i] = perm[k];
        perm[k] = tmp;
      end

      if (graph == 3) n_edges = $urandom_range(66, 70);
      else n_edges = $urandom_range(0, (2 * n_eff < 14) ? 2 * n_eff : 14);

      for (int e = 0; e < n_edges; e++) begin
        r = $urandom_range(0, 9);
        if (r < 8 && n_eff >= 2) begin
          a = $urandom_range(0, n_eff - 2);
          b = $urandom_range(a + 1, n_eff - 1);
          send(MODE_EDGE, perm[a], perm[b]);
        end else if (r == 9 && n_eff < 16) begin
          // out of range on one end or the other
          if ($urandom_range(0, 1))
            send(MODE_EDGE, VID_W'($urandom_range(n_eff, 15)),
                 VID_W'($urandom_range(0, 15)));
          else
            send(MODE_EDGE, VID_W'($urandom_range(0, 15)),
                 VID_W'($urandom_range(n_eff, 15)));
        end else begin
          // anything goes: may close a cycle or fall out of range
          send(MODE_EDGE, VID_W'($urandom_range(0, 15)), VID_W'($urandom_range(0, 15)));
        end
      end
      send(MODE_SORT, VID_W'($urandom_range(0, 15)), VID_W'($urandom_range(0, 15)));
      graph++;
    end

    settle();
    if (fails == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
